[rtl/mpf_pkg.sv]
`timescale 1ns / 1ps
// mpf_pkg: shared types, character constants and lookup functions for the formatter
// no dependencies; used by mini_printf_formatter_core

package mpf_pkg;

    localparam int FMT_W      = 8;
    localparam int ARG_W      = 32;
    localparam int IN_TDATA_W = 40;   // fmt_byte + argument, already whole bytes
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 10;   // enough for any 32-bit value
    localparam int DIG_W      = DEC_DIGITS * DIGIT_W;
    localparam int CNT_W      = 5;

    localparam logic [CNT_W-1:0] TEXT_LEN  = 5'd21;
    localparam logic [CNT_W-1:0] HEAD_LEN  = 5'd18;
    localparam logic [CNT_W-1:0] DEC_BITS  = 5'd31; // bit steps minus one
    localparam logic [CNT_W-1:0] DEC_LEN   = 5'd10;
    localparam logic [CNT_W-1:0] HEX8_LEN  = 5'd8;
    localparam logic [CNT_W-1:0] HEX4_LEN  = 5'd4;
    localparam logic [CNT_W-1:0] HEX2_LEN  = 5'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CASE    = 8'h20;  // or-ing folds upper case to lower
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_C   = 8'h63;

    typedef enum logic [1:0] {
        MODE_HEX  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_TEXT = 2'd2
    } mode_t;

    // digit 0..15 to upper-case ascii
    function automatic logic [7:0] hex_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = 8'h30 + {4'd0, d};
        else
            c = 8'h37 + {4'd0, d};
        return c;
    endfunction

    // character of the unknown-format message at position idx
    function automatic logic [7:0] text_char(input logic [CNT_W-1:0] idx,
                                             input logic [7:0] fmt);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h20;  // ' '
            5'd1:    c = 8'h5B;  // '['
            5'd2:    c = 8'h55;  // 'U'
            5'd3:    c = 8'h6E;  // 'n'
            5'd4:    c = 8'h6B;  // 'k'
            5'd5:    c = 8'h6E;  // 'n'
            5'd6:    c = 8'h6F;  // 'o'
            5'd7:    c = 8'h77;  // 'w'
            5'd8:    c = 8'h6E;  // 'n'
            5'd9:    c = 8'h20;  // ' '
            5'd10:   c = 8'h66;  // 'f'
            5'd11:   c = 8'h6F;  // 'o'
            5'd12:   c = 8'h72;  // 'r'
            5'd13:   c = 8'h6D;  // 'm'
            5'd14:   c = 8'h61;  // 'a'
            5'd15:   c = 8'h74;  // 't'
            5'd16:   c = 8'h3A;  // ':'
            5'd17:   c = 8'h20;  // ' '
            5'd18:   c = fmt;
            5'd19:   c = 8'h5D;  // ']'
            5'd20:   c = 8'h20;  // ' '
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

[rtl/mini_printf_formatter_core.sv]
`timescale 1ns / 1ps
// mini_printf_formatter_core: printf-style formatter, one format byte in, ascii characters out
// depends on mpf_pkg for constants, modes and character lookup
//
// channel   dir  tdata fields (low bit up)            tlast
// s_axis    in   fmt_byte[7:0], argument[39:8]       -
// m_axis    out  out_char[7:0]                       last char caused by one item
//
// work per item:
//   plain byte, %c, %% : the character itself; a lone percent sign is taken and emits nothing
//   %x / %h / %b       : hex digits, one at a time from the top of the digit register
//   %d                 : bit-serial double-dabble bcd conversion, then leading zeros are
//                        skipped without output and the remaining digits are emitted
//   unknown letter     : the unknown-format message, one character at a time
// reset (rst_n low, async) empties the output register and clears the pending percent flag.
// a stalled m_tready holds the current character; the block takes a new item only when idle
// and the output register is free or being drained in the same cycle.

module mini_printf_formatter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // fmt_byte[7:0], argument[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic        m_tlast
);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DEC  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                             state_reg,   state_next;
    mpf_pkg::mode_t                     mode_reg,    mode_next;
    logic                               pend_reg,    pend_next;
    logic                               started_reg, started_next;
    logic [mpf_pkg::CNT_W-1:0]          cnt_reg,     cnt_next;
    logic [mpf_pkg::ARG_W-1:0]          sh_reg,      sh_next;
    logic [mpf_pkg::DIG_W-1:0]          dig_reg,     dig_next;
    logic [mpf_pkg::FMT_W-1:0]          fmt_reg,     fmt_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [7:0]                         m_tdata_reg,  m_tdata_next;
    logic                               m_tlast_reg,  m_tlast_next;

    logic [mpf_pkg::FMT_W-1:0]          fmt_in;
    logic [mpf_pkg::ARG_W-1:0]          arg_in;
    logic [7:0]                         fmt_fold;
    logic                               slot_free;
    logic                               s_fire;
    logic [mpf_pkg::DIG_W-1:0]          dig_adj;
    logic [mpf_pkg::DIGIT_W-1:0]        top_digit;
    logic                               skip_zero;
    logic [7:0]                         emit_char;

    assign fmt_in   = s_tdata[7:0];
    assign arg_in   = s_tdata[39:8];
    assign fmt_fold = fmt_in | mpf_pkg::CH_CASE;

    // output register frees up when empty or drained this cycle
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // double-dabble add-3 on every bcd digit, independent per digit
    always_comb
    begin
        for (int i = 0; i < mpf_pkg::DEC_DIGITS; i++)
        begin
            if (dig_reg[i*mpf_pkg::DIGIT_W +: mpf_pkg::DIGIT_W] >= 4'd5)
                dig_adj[i*mpf_pkg::DIGIT_W +: mpf_pkg::DIGIT_W] =
                    dig_reg[i*mpf_pkg::DIGIT_W +: mpf_pkg::DIGIT_W] + 4'd3;
            else
                dig_adj[i*mpf_pkg::DIGIT_W +: mpf_pkg::DIGIT_W] =
                    dig_reg[i*mpf_pkg::DIGIT_W +: mpf_pkg::DIGIT_W];
        end
    end

    // next character comes from the top digit of the digit register or the message table
    assign top_digit = dig_reg[mpf_pkg::DIG_W-1 -: mpf_pkg::DIGIT_W];
    assign skip_zero = (mode_reg == mpf_pkg::MODE_DEC) && !started_reg
                       && (top_digit == 4'd0) && (cnt_reg > 5'd1);

    always_comb
    begin
        case (mode_reg)
            mpf_pkg::MODE_TEXT: emit_char = mpf_pkg::text_char(mpf_pkg::TEXT_LEN - cnt_reg,
                                                                 fmt_reg);
            default:            emit_char = mpf_pkg::hex_char(top_digit);
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pend_next     = pend_reg;
        started_next  = started_reg;
        cnt_next      = cnt_reg;
        sh_next       = sh_reg;
        dig_next      = dig_reg;
        fmt_next      = fmt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (!pend_reg)
                    begin
                        if (fmt_in == mpf_pkg::CH_PERCENT)
                            pend_next = 1'b1;
                        else
                        begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = fmt_in;
                            m_tlast_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_next    = 1'b0;
                        started_next = 1'b0;
                        fmt_next     = fmt_in;
                        if (fmt_in == mpf_pkg::CH_PERCENT)
                        begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = mpf_pkg::CH_PERCENT;
                            m_tlast_next  = 1'b1;
                        end
                        else
                        begin
                            case (fmt_fold)
                                mpf_pkg::CH_LOW_C:
                                begin
                                    m_tvalid_next = 1'b1;
                                    m_tdata_next  = arg_in[7:0];
                                    m_tlast_next  = 1'b1;
                                end
                                mpf_pkg::CH_LOW_X:
                                begin
                                    mode_next  = mpf_pkg::MODE_HEX;
                                    dig_next   = {arg_in, 8'd0};
                                    cnt_next   = mpf_pkg::HEX8_LEN;
                                    state_next = ST_EMIT;
                                end
                                mpf_pkg::CH_LOW_H:
                                begin
                                    mode_next  = mpf_pkg::MODE_HEX;
                                    dig_next   = {arg_in[15:0], 24'd0};
                                    cnt_next   = mpf_pkg::HEX4_LEN;
                                    state_next = ST_EMIT;
                                end
                                mpf_pkg::CH_LOW_B:
                                begin
                                    mode_next  = mpf_pkg::MODE_HEX;
                                    dig_next   = {arg_in[7:0], 32'd0};
                                    cnt_next   = mpf_pkg::HEX2_LEN;
                                    state_next = ST_EMIT;
                                end
                                mpf_pkg::CH_LOW_D:
                                begin
                                    mode_next  = mpf_pkg::MODE_DEC;
                                    sh_next    = arg_in;
                                    dig_next   = '0;
                                    cnt_next   = mpf_pkg::DEC_BITS;
                                    state_next = ST_DEC;
                                end
                                default:
                                begin
                                    mode_next  = mpf_pkg::MODE_TEXT;
                                    cnt_next   = mpf_pkg::TEXT_LEN;
                                    state_next = ST_EMIT;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_DEC:
            begin
                // one binary bit into the bcd register per cycle, msb first
                dig_next = {dig_adj[mpf_pkg::DIG_W-2:0], sh_reg[mpf_pkg::ARG_W-1]};
                sh_next  = {sh_reg[mpf_pkg::ARG_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next   = mpf_pkg::DEC_LEN;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg - 5'd1;
            end

            ST_EMIT:
            begin
                if (skip_zero)
                begin
                    // drop a leading zero digit, no output
                    dig_next = {dig_reg[mpf_pkg::DIG_W-mpf_pkg::DIGIT_W-1:0], 4'd0};
                    cnt_next = cnt_reg - 5'd1;
                end
                else if (slot_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = emit_char;
                    m_tlast_next  = (cnt_reg == 5'd1);
                    started_next  = 1'b1;
                    dig_next      = {dig_reg[mpf_pkg::DIG_W-mpf_pkg::DIGIT_W-1:0], 4'd0};
                    cnt_next      = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        started_reg <= started_next;
        cnt_reg     <= cnt_next;
        sh_reg      <= sh_next;
        dig_reg     <= dig_next;
        fmt_reg     <= fmt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef SYNTHESIS
    // emission never runs with an exhausted counter
    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("emit state with zero count");

    // a fresh percent sign arms the flag and emits nothing
    a_percent_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !pend_reg && (fmt_in == mpf_pkg::CH_PERCENT))
        |=> (pend_reg && (m_tvalid_reg == ($past(m_tvalid_reg) && !$past(m_tready)))))
        else $error("percent sign did not arm cleanly");

    // bcd conversion leaves a valid decimal digit on top
    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (mode_reg == mpf_pkg::MODE_DEC)) |-> (top_digit <= 4'd9))
        else $error("bcd digit out of range");

    // a multi-character item ends with a last character in the output register
    a_emit_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && $past(state_reg == ST_EMIT)) |-> (m_tvalid_reg && m_tlast_reg))
        else $error("emission ended without last");
`endif

endmodule
